// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_READ       = 2'd2,
    OP_WRITE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  position;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_e     status;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  element_count;
    logic        is_empty;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

// ===== rtl/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dq_ctrl.sv =====
module dq_ctrl
  import dq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && out_stall_i;
    cmd_o.latch_item = 1'b0;
    cmd_o.exec       = 1'b0;
    cmd_o.load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        // wait here until the output register can take the item
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/dq_datapath.sv =====
module dq_datapath
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_i,
  output out_t out_o
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (PW > CW) ? PW : CW;
  localparam int AW = ((MW > 4) ? MW : 4) + 1;

  in_t                   item_q;
  logic [PW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;
  status_e               status_q, status_d;
  logic                  rd_ok_q, rd_ok_d;
  out_t                  out_q, out_d;

  logic [AW-1:0]         pos_ext, cnt_ext, offset, sum, wrapped;
  logic [PW-1:0]         head_dec, slot;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic                  full, empty, in_range, is_last, we;

  assign pos_ext  = AW'(item_q.position);
  assign cnt_ext  = AW'(count_q);
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign in_range = (pos_ext < cnt_ext);
  assign is_last  = (pos_ext == cnt_ext - AW'(1));
  assign offset   = (item_q.op == OP_PUSH_BACK) ? cnt_ext : pos_ext;
  // head plus offset stays below twice the capacity, one subtract wraps it
  assign sum      = AW'(head_q) + offset;
  assign wrapped  = (sum >= AW'(CAPACITY)) ? sum - AW'(CAPACITY) : sum;
  assign slot     = wrapped[PW-1:0];
  assign head_dec = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - PW'(1);
  assign wdata    = DATA_WIDTH'(item_q.value);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    front_d  = front_q;
    back_d   = back_q;
    status_d = ST_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    unique case (item_q.op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          head_d  = head_dec;
          we      = 1'b1;
          front_d = wdata;
          if (empty) begin
            back_d = wdata;
          end
          count_d = count_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          back_d = wdata;
          if (empty) begin
            front_d = wdata;
          end
          count_d = count_q + CW'(1);
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          we = 1'b1;
          if (pos_ext == '0) begin
            front_d = wdata;
          end
          if (is_last) begin
            back_d = wdata;
          end
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  dq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we && cmd_i.exec),
    .waddr_i((item_q.op == OP_PUSH_FRONT) ? head_dec : slot),
    .wdata_i(wdata),
    .re_i   (cmd_i.exec),
    .raddr_i(slot),
    .rdata_o(rdata)
  );

  always_comb begin
    out_d.read_data     = rd_ok_q ? 32'(rdata) : '0;
    out_d.status        = status_q;
    out_d.front_value   = empty ? '0 : 32'(front_q);
    out_d.back_value    = empty ? '0 : 32'(back_q);
    out_d.element_count = 5'(count_q);
    out_d.is_empty      = empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_i;
    end
    if (cmd_i.exec) begin
      front_q  <= front_d;
      back_q   <= back_d;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// an accepted item passes through the item register, the slot ram access with its
// registered read, and the load of the output register, which waits while the output stalls
// a new item is accepted only after the previous one is loaded into the output register
// the next item is taken while a finished result still waits in the output register
// reset clears head pointer, element count and handshake state; slot ram is not cleared
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  dq_datapath #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .in_i  (in_i),
    .out_o (out_o)
  );

  // one item in flight: an accepted item blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // an empty deque reports zero front and back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.is_empty) |->
      (out_o.front_value == '0 && out_o.back_value == '0))
    else $error("front or back nonzero on empty deque");

  // only an in-range read returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != ST_OK) |-> (out_o.read_data == '0))
    else $error("read data on failed item");

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
module tb_double_ended_queue;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 600;

  typedef enum logic [1:0] {
    ENT_OP,
    ENT_HOLD,
    ENT_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    in_t         payload;
    bit          steady;
  } op_entry_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_i        = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_o;

  // deque model state
  logic [31:0] model_slot [DEPTH];
  logic [3:0]  model_head  = '0;
  logic [4:0]  model_count = '0;

  op_entry_t ops_pending [$];
  out_t      deque_results_due [$];

  logic steady_run   = 1'b0;
  logic hold_request = 1'b0;
  int   hold_left    = 0;
  int   gen_count    = 0;
  int   ops_applied  = 0;
  int   results_seen = 0;
  int   full_drops   = 0;
  int   range_misses = 0;
  int   errors       = 0;
  int   cycles       = 0;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  function automatic out_t deque_apply(in_t item);
    out_t       r;
    logic [3:0] slot;
    r = '0;
    r.status = ST_OK;
    case (item.op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_count == DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          if (item.op == OP_PUSH_FRONT) begin
            model_head = model_head - 4'd1;
            slot = model_head;
          end else begin
            slot = model_head + model_count[3:0];
          end
          model_slot[slot] = item.value;
          model_count++;
        end
      end
      default: begin
        if ({1'b0, item.position} >= model_count) begin
          r.status = ST_RANGE;
          range_misses++;
        end else begin
          slot = model_head + item.position;
          if (item.op == OP_READ) r.read_data = model_slot[slot];
          else model_slot[slot] = item.value;
        end
      end
    endcase
    if (model_count != 0) begin
      r.front_value = model_slot[model_head];
      slot = model_head + 4'(model_count - 5'd1);
      r.back_value = model_slot[slot];
    end
    r.element_count = model_count;
    r.is_empty = (model_count == 0);
    return r;
  endfunction

  task automatic add_op(op_e op, logic [3:0] position, logic [31:0] value, bit steady);
    op_entry_t e;
    e.kind = ENT_OP;
    e.payload.op = op;
    e.payload.position = position;
    e.payload.value = value;
    e.steady = steady;
    ops_pending = {ops_pending, e};
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH) gen_count++;
  endtask

  task automatic add_marker(entry_kind_e kind);
    op_entry_t e;
    e.kind = kind;
    e.payload = '0;
    e.steady = 1'b0;
    ops_pending = {ops_pending, e};
  endtask

  task automatic add_random(bit steady);
    int          pick;
    op_e         op;
    logic [3:0]  position;
    logic [31:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 5) op = OP_PUSH_FRONT;
    else if (pick < 10) op = OP_PUSH_BACK;
    else if (pick < 55) op = OP_READ;
    else op = OP_WRITE;
    // mostly legal indexes, some past the count while the deque is filling
    if (gen_count == 0 || $urandom_range(0, 99) < 15) position = 4'($urandom_range(0, 15));
    else position = 4'($urandom_range(0, gen_count - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) value = '0;
    else if (pick < 10) value = '1;
    else value = $urandom;
    add_op(op, position, value, steady);
  endtask

  // sender
  always @(posedge clk_i) begin : drive_proc
    logic      offer;
    logic      pulse;
    op_entry_t next_entry;
    offer = in_valid_i;
    pulse = 1'b0;
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        deque_results_due = {deque_results_due, deque_apply(in_i)};
        ops_applied++;
      end
      offer = 1'b0;
      // a drain entry holds the sender until every result is back
      while (ops_pending.size() != 0 && ops_pending[0].kind != ENT_OP &&
             !(ops_pending[0].kind == ENT_DRAIN && deque_results_due.size() != 0)) begin
        if (ops_pending[0].kind == ENT_HOLD) pulse = 1'b1;
        ops_pending.delete(0);
      end
      if (ops_pending.size() != 0 && ops_pending[0].kind == ENT_OP &&
          (ops_pending[0].steady || $urandom_range(0, 99) >= 28)) begin
        next_entry = ops_pending.pop_front();
        in_i <= next_entry.payload;
        steady_run <= next_entry.steady;
        offer = 1'b1;
      end
    end
    in_valid_i <= offer;
    hold_request <= pulse;
  end

  // receiver and checker
  always @(posedge clk_i) begin : collect_proc
    out_t want;
    logic hold_now;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (deque_results_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_o);
          errors++;
        end else begin
          want = deque_results_due.pop_front();
          if (out_o.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     out_o.read_data);
            errors++;
          end
          if (out_o.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_o.status);
            errors++;
          end
          if (out_o.front_value !== want.front_value) begin
            $display("%0t: front_value expected %h actual %h", $time, want.front_value,
                     out_o.front_value);
            errors++;
          end
          if (out_o.back_value !== want.back_value) begin
            $display("%0t: back_value expected %h actual %h", $time, want.back_value,
                     out_o.back_value);
            errors++;
          end
          if (out_o.element_count !== want.element_count) begin
            $display("%0t: element_count expected %0d actual %0d", $time,
                     want.element_count, out_o.element_count);
            errors++;
          end
          if (out_o.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time, want.is_empty,
                     out_o.is_empty);
            errors++;
          end
        end
      end
      if (hold_request) hold_left = HOLD_CYCLES;
      hold_now = (hold_left != 0);
      if (hold_now) hold_left--;
      out_stall_i <= hold_now || (!steady_run && $urandom_range(0, 99) < 28);
    end
  end

  initial begin
    // empty deque: index errors, then a partly filled one
    add_op(OP_READ, 4'd0, 32'h0, 1'b0);
    add_op(OP_WRITE, 4'd15, 32'hFFFF_FFFF, 1'b0);
    add_op(OP_PUSH_BACK, 4'd0, 32'hFFFF_FFFF, 1'b0);
    add_op(OP_PUSH_FRONT, 4'd15, 32'h0000_0000, 1'b0);
    add_op(OP_PUSH_FRONT, 4'd0, 32'h8000_0001, 1'b0);
    add_op(OP_READ, 4'd0, 32'h0, 1'b0);
    add_op(OP_READ, 4'd1, 32'h0, 1'b0);
    add_op(OP_READ, 4'd2, 32'h0, 1'b0);
    add_op(OP_READ, 4'd3, 32'h0, 1'b0);
    add_op(OP_WRITE, 4'd2, 32'h5A5A_A5A5, 1'b0);
    add_op(OP_WRITE, 4'd0, 32'hFFFF_FFFF, 1'b0);
    add_op(OP_WRITE, 4'd3, 32'h1111_1111, 1'b0);
    add_op(OP_READ, 4'd15, 32'h0, 1'b0);
    add_op(OP_PUSH_BACK, 4'd0, 32'h1234_5678, 1'b0);
    add_op(OP_READ, 4'd3, 32'h0, 1'b0);
    add_marker(ENT_DRAIN);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 200) add_marker(ENT_HOLD);
      if (i == 450) add_marker(ENT_DRAIN);
      add_random(i >= 300 && i < 380);
    end

    // fill up if not yet full, then the full and last-index cases
    while (gen_count < DEPTH) add_op(OP_PUSH_BACK, 4'd0, $urandom, 1'b0);
    add_op(OP_PUSH_FRONT, 4'd0, 32'hDEAD_0001, 1'b0);
    add_op(OP_PUSH_BACK, 4'd0, 32'hDEAD_0002, 1'b0);
    add_op(OP_READ, 4'd15, 32'h0, 1'b0);
    add_op(OP_WRITE, 4'd15, 32'h0F0F_F0F0, 1'b0);
    add_op(OP_WRITE, 4'd0, 32'h0000_0000, 1'b0);
    add_op(OP_READ, 4'd0, 32'h0, 1'b0);
    add_op(OP_READ, 4'd15, 32'h0, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (deque_results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d items applied, %0d results checked, %0d full drops, %0d index errors",
             ops_applied, results_seen, full_drops, range_misses);
    $display("phases: empty and partial deque, fill to capacity, idle gaps, output hold-off, drains");
    if (errors == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
